>>> rtl/core/plb_pkg.sv
// Shared types and codes for the positional list buffer.
// Used by plb_ctrl, plb_dp and the top level; depends on nothing.
package plb_pkg;

	// Action codes
	localparam logic [2:0] ACT_ADD_FRONT  = 3'd0;
	localparam logic [2:0] ACT_ADD_REAR   = 3'd1;
	localparam logic [2:0] ACT_DEL_FRONT  = 3'd2;
	localparam logic [2:0] ACT_DEL_REAR   = 3'd3;
	localparam logic [2:0] ACT_INSERT_POS = 3'd4;
	localparam logic [2:0] ACT_DEL_POS    = 3'd5;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [1:0] ST_RANGE     = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_TAKE,
		S_GRAB,
		S_READ,
		S_WRITE,
		S_PUT,
		S_FIN
	} state_t;

	typedef enum logic [1:0] {
		K_NONE,
		K_INSERT,
		K_REMOVE
	} kind_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;      // latch a new word and decode it
		logic take;        // read the entry being removed
		logic grab;        // capture the removed entry
		logic read_shift;  // read the neighbour of the move pointer
		logic write_shift; // write the neighbour at the move pointer, step it
		logic put;         // write the new element at its slot
		logic finish;      // update the count
	} plb_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		kind_t kind;       // what the current word does to the list
		logic  more;       // one more entry still has to move
	} plb_stat_t;

endpackage

>>> rtl/core/plb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module plb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/plb_ctrl.sv
// Sequencer for the positional list buffer.
// Depends on plb_pkg; drives plb_dp through plb_cmd_t.
module plb_ctrl import plb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  plb_stat_t stat,
	output plb_cmd_t  cmd,
	output logic      busy,
	output logic      done
);

	state_t state_q, state_d;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_FIN);
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				case (stat.kind)
					K_INSERT: state_d = S_READ;
					K_REMOVE: state_d = S_TAKE;
					default:  state_d = S_FIN;
				endcase
			end
			S_TAKE:  state_d = S_GRAB;
			S_GRAB:  state_d = S_READ;
			S_READ: begin
				if (stat.more)                 state_d = S_WRITE;
				else if (stat.kind == K_INSERT) state_d = S_PUT;
				else                           state_d = S_FIN;
			end
			S_WRITE: state_d = S_READ;
			S_PUT:   state_d = S_FIN;
			S_FIN:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd             = '0;
		cmd.accept      = (state_q == S_IDLE) && start;
		cmd.take        = (state_q == S_TAKE);
		cmd.grab        = (state_q == S_GRAB);
		cmd.read_shift  = (state_q == S_READ);
		cmd.write_shift = (state_q == S_WRITE);
		cmd.put         = (state_q == S_PUT);
		cmd.finish      = (state_q == S_FIN);
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

>>> rtl/core/plb_dp.sv
// Datapath of the positional list buffer: decode, count, move pointer and store.
// Depends on plb_pkg and plb_ram.
module plb_dp import plb_pkg::*; #(
	parameter int DEPTH         = 16,
	parameter int ELEMENT_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  plb_cmd_t                   cmd,
	input  logic [2:0]                 action,
	input  logic [4:0]                 position,
	input  logic [31:0]                value,
	output plb_stat_t                  stat,
	output logic [1:0]                 status,
	output logic [31:0]                removed_value,
	output logic [$clog2(DEPTH+1)-1:0] element_count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic [CW-1:0]            count_q;
	logic [CW-1:0]            ptr_q;
	logic [AW-1:0]            idx_q;
	kind_t                    kind_q;
	logic [1:0]               status_q;
	logic [31:0]              removed_q;
	logic [ELEMENT_WIDTH-1:0] value_q;

	// Decode of the incoming word against the current count
	logic [31:0]   pos32, cnt32;
	logic          full, empty;
	kind_t         kind_d;
	logic [1:0]    status_d;
	logic [31:0]   idx32;

	assign pos32 = 32'(position);
	assign cnt32 = 32'(count_q);
	assign full  = (cnt32 >= DEPTH);
	assign empty = (count_q == '0);

	always_comb begin
		kind_d   = K_NONE;
		status_d = ST_OK;
		idx32    = '0;
		case (action)
			ACT_ADD_FRONT: begin
				if (full) status_d = ST_FULL;
				else kind_d = K_INSERT;
			end
			ACT_ADD_REAR: begin
				idx32 = cnt32;
				if (full) status_d = ST_FULL;
				else kind_d = K_INSERT;
			end
			ACT_DEL_FRONT: begin
				if (empty) status_d = ST_UNDERFLOW;
				else kind_d = K_REMOVE;
			end
			ACT_DEL_REAR: begin
				idx32 = cnt32 - 32'd1;
				if (empty) status_d = ST_UNDERFLOW;
				else kind_d = K_REMOVE;
			end
			ACT_INSERT_POS: begin
				idx32 = pos32 - 32'd1;
				if (pos32 < 32'd1 || pos32 > cnt32 + 32'd1) status_d = ST_RANGE;
				else if (full) status_d = ST_FULL;
				else kind_d = K_INSERT;
			end
			ACT_DEL_POS: begin
				idx32 = pos32 - 32'd1;
				if (pos32 < 32'd1 || pos32 > cnt32) status_d = ST_RANGE;
				else kind_d = K_REMOVE;
			end
			default: ;
		endcase
	end

	// Move pointer arithmetic
	logic [CW:0]   ptr_up;
	logic [CW-1:0] ptr_dn;
	logic [AW-1:0] shift_raddr;

	assign ptr_up = {1'b0, ptr_q} + (CW+1)'(1);
	assign ptr_dn = ptr_q - CW'(1);
	assign shift_raddr = (kind_q == K_INSERT) ? ptr_dn[AW-1:0] : ptr_up[AW-1:0];

	always_comb begin
		stat.kind = kind_q;
		if (kind_q == K_INSERT) stat.more = (ptr_q > CW'(idx_q));
		else                    stat.more = (ptr_up < {1'b0, count_q});
	end

	// Store
	logic                     we;
	logic [AW-1:0]            waddr, raddr;
	logic [ELEMENT_WIDTH-1:0] wdata, rdata;

	assign we    = cmd.write_shift | cmd.put;
	assign waddr = cmd.put ? idx_q : ptr_q[AW-1:0];
	assign wdata = cmd.put ? value_q : rdata;
	assign raddr = cmd.take ? idx_q : shift_raddr;

	plb_ram #(
		.WIDTH (ELEMENT_WIDTH),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			kind_q  <= K_NONE;
		end else begin
			if (cmd.accept) kind_q <= kind_d;
			if (cmd.finish) begin
				if (kind_q == K_INSERT)      count_q <= count_q + CW'(1);
				else if (kind_q == K_REMOVE) count_q <= count_q - CW'(1);
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			idx_q     <= idx32[AW-1:0];
			ptr_q     <= (kind_d == K_INSERT) ? count_q : CW'(idx32[AW-1:0]);
			status_q  <= status_d;
			removed_q <= '0;
			value_q   <= ELEMENT_WIDTH'(value);
		end else begin
			if (cmd.grab) removed_q <= 32'(rdata);
			if (cmd.write_shift) begin
				if (kind_q == K_INSERT) ptr_q <= ptr_dn;
				else                    ptr_q <= ptr_up[CW-1:0];
			end
		end
	end

	assign status        = status_q;
	assign removed_value = removed_q;
	assign element_count = count_q;

endmodule

>>> rtl/core/positional_list_buffer.sv
// Top level of the positional list buffer: ordered list with positional add/remove.
// Depends on plb_pkg, plb_ctrl, plb_dp (which holds plb_ram).
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------------------
//  command | action, position, value                 | taken when start & !busy
//  result  | status, removed_value, element_count    | one-cycle strobe on done
//
// One command word is worked at a time. A word that fails or changes nothing goes
// from acceptance through the decide and finish states to the done strobe. An add or remove moves
// every entry behind its slot one place through the store RAM, each moved entry
// read and then written on the single port pair: an insert moves its entries and
// then writes the new element, while a remove first reads and captures the removed
// entry and then moves its entries. busy falls in the cycle done is high, so the
// next word may be taken then. Reset empties the list at once; the store needs
// no clearing since only entries below the count are ever read. The receiver
// cannot stall: each result holds on its ports until the next word is taken.
module positional_list_buffer import plb_pkg::*; #(
	parameter int DEPTH         = 16,
	parameter int ELEMENT_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [2:0]                 action,
	input  logic [4:0]                 position,
	input  logic [31:0]                value,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [31:0]                removed_value,
	output logic [$clog2(DEPTH+1)-1:0] element_count
);

	plb_cmd_t  cmd;
	plb_stat_t stat;

	// Sequence the word: decode, capture on remove, move entries, write on insert, finish
	plb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Hold the count, the move pointer, the result and the store
	plb_dp #(
		.DEPTH         (DEPTH),
		.ELEMENT_WIDTH (ELEMENT_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.action        (action),
		.position      (position),
		.value         (value),
		.stat          (stat),
		.status        (status),
		.removed_value (removed_value),
		.element_count (element_count)
	);

endmodule
